### src/assert_macros.svh
// Assertion macros for the arc length RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define CAL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property failed");

// Condition must never be seen outside reset.
`define CAL_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define CAL_ASSERT(lbl, clk, rstn, prop)
`define CAL_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### src/cal_pkg.sv
// Shared constants, tables and beat types of the arc length pipeline.
package cal_pkg;

    // CORDIC iterations, one pipeline stage each (8 to 32)
    localparam int CORDIC_STEPS = 16;

    localparam int IN_W     = 32;   // coordinate and radius width
    localparam int OFS_W    = 33;   // offset from the centre
    localparam int CW       = 45;   // CORDIC datapath, normalized to 2^40..2^41
    localparam int ANG_W    = 32;   // binary turns, 2^32 per turn
    localparam int LEN_W    = 34;   // Q18.16 arc length
    localparam int SH_W     = 6;    // normalizing shift amount
    localparam int NORM_EXP = 40;   // larger magnitude is scaled to 2^40 or more
    localparam int LANES    = 2;    // start point and end point

    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [IN_W-1:0]  PI_Q30       = 32'hC90F_DAA2;

    // atan(2^-k) in binary turns, rounded to nearest
    localparam logic [ANG_W-1:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // One arc as it enters the pipeline
    typedef struct packed {
        logic signed [IN_W-1:0] start_x;
        logic signed [IN_W-1:0] start_y;
        logic signed [IN_W-1:0] end_x;
        logic signed [IN_W-1:0] end_y;
        logic signed [IN_W-1:0] center_x;
        logic signed [IN_W-1:0] center_y;
        logic        [IN_W-1:0] radius;
    } t_arc;

    typedef struct packed {
        logic valid;
        t_arc arc;
    } t_in;

    // CORDIC vector of one endpoint
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANG_W-1:0]     z;
        logic                 zero;   // endpoint on the centre
    } t_lane;

    typedef struct packed {
        logic                 valid;
        t_lane [LANES-1:0]    lane;   // lane 0 start, lane 1 end
        logic [IN_W-1:0]      radius;
    } t_vec;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
    } t_res;

endpackage

### src/cal_front.sv
// Front end: offsets from the centre, normalization and quadrant fold.
module cal_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  cal_pkg::t_in  i_in,
    output cal_pkg::t_vec o_vec
);
    import cal_pkg::*;

    // stage 1: offsets, x mirrored
    logic                    r1_valid;
    logic signed [OFS_W-1:0] r1_dx [LANES];
    logic signed [OFS_W-1:0] r1_dy [LANES];
    logic [IN_W-1:0]         r1_rad;

    // stage 2: shift amount and folded vector
    logic                    r2_valid;
    logic signed [OFS_W-1:0] r2_x [LANES];
    logic signed [OFS_W-1:0] r2_y [LANES];
    logic [ANG_W-1:0]        r2_z [LANES];
    logic [SH_W-1:0]         r2_sh [LANES];
    logic                    r2_zero [LANES];
    logic [IN_W-1:0]         r2_rad;

    // stage 3: scaled vector
    t_vec r3_vec;

    logic signed [OFS_W-1:0] n_dx [LANES];
    logic signed [OFS_W-1:0] n_dy [LANES];
    logic signed [OFS_W-1:0] n_x [LANES];
    logic signed [OFS_W-1:0] n_y [LANES];
    logic [ANG_W-1:0]        n_z [LANES];
    logic [SH_W-1:0]         n_sh [LANES];
    logic                    n_zero [LANES];
    t_vec                    n_vec;

    function automatic logic [4:0] msb_pos(input logic [IN_W-1:0] v);
        logic [4:0] p;
        p = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (v[b]) begin
                p = 5'(b);
            end
        end
        return p;
    endfunction

    // offsets: dx = c.x - p.x, dy = p.y - c.y
    always_comb begin
        n_dx[0] = {i_in.arc.center_x[IN_W-1], i_in.arc.center_x}
                - {i_in.arc.start_x[IN_W-1], i_in.arc.start_x};
        n_dy[0] = {i_in.arc.start_y[IN_W-1], i_in.arc.start_y}
                - {i_in.arc.center_y[IN_W-1], i_in.arc.center_y};
        n_dx[1] = {i_in.arc.center_x[IN_W-1], i_in.arc.center_x}
                - {i_in.arc.end_x[IN_W-1], i_in.arc.end_x};
        n_dy[1] = {i_in.arc.end_y[IN_W-1], i_in.arc.end_y}
                - {i_in.arc.center_y[IN_W-1], i_in.arc.center_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_in.valid;
            r1_dx    <= n_dx;
            r1_dy    <= n_dy;
            r1_rad   <= i_in.arc.radius;
        end
    end

    // leading one of the larger magnitude, fold left half plane to the right
    always_comb begin
        logic [OFS_W-1:0] ax;
        logic [OFS_W-1:0] ay;
        logic [IN_W-1:0]  mor;
        for (int l = 0; l < LANES; l++) begin
            ax = r1_dx[l][OFS_W-1] ? OFS_W'(-r1_dx[l]) : OFS_W'(r1_dx[l]);
            ay = r1_dy[l][OFS_W-1] ? OFS_W'(-r1_dy[l]) : OFS_W'(r1_dy[l]);
            mor = ax[IN_W-1:0] | ay[IN_W-1:0];
            n_zero[l] = (mor == '0);
            n_sh[l] = SH_W'(NORM_EXP) - {1'b0, msb_pos(mor)};
            if (!r1_dx[l][OFS_W-1]) begin
                n_x[l] = r1_dx[l];
                n_y[l] = r1_dy[l];
                n_z[l] = '0;
            end else if (!r1_dy[l][OFS_W-1]) begin
                n_x[l] = r1_dy[l];
                n_y[l] = -r1_dx[l];
                n_z[l] = QUARTER_TURN;
            end else begin
                n_x[l] = -r1_dy[l];
                n_y[l] = r1_dx[l];
                n_z[l] = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
            r2_x     <= n_x;
            r2_y     <= n_y;
            r2_z     <= n_z;
            r2_sh    <= n_sh;
            r2_zero  <= n_zero;
            r2_rad   <= r1_rad;
        end
    end

    // exact power-of-two scaling into the CORDIC width
    always_comb begin
        logic signed [CW-1:0] xe;
        logic signed [CW-1:0] ye;
        n_vec.valid  = r2_valid;
        n_vec.radius = r2_rad;
        for (int l = 0; l < LANES; l++) begin
            xe = {{(CW-OFS_W){r2_x[l][OFS_W-1]}}, r2_x[l]};
            ye = {{(CW-OFS_W){r2_y[l][OFS_W-1]}}, r2_y[l]};
            n_vec.lane[l].x    = xe <<< r2_sh[l];
            n_vec.lane[l].y    = ye <<< r2_sh[l];
            n_vec.lane[l].z    = r2_z[l];
            n_vec.lane[l].zero = r2_zero[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vec.valid <= 1'b0;
        end else if (i_en) begin
            r3_vec <= n_vec;
        end
    end

    assign o_vec = r3_vec;

endmodule

### src/cal_cordic.sv
// Unrolled vectoring CORDIC, one micro-rotation per pipeline stage, two lanes.
module cal_cordic (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  cal_pkg::t_vec i_vec,
    output cal_pkg::t_vec o_vec
);
    import cal_pkg::*;

    t_vec w_st [CORDIC_STEPS+1];

    assign w_st[0] = i_vec;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        localparam int K = g % 32;

        t_vec r_st;
        t_vec n_st;

        // rotate toward the x axis, accumulate the angle
        always_comb begin
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            n_st = w_st[g];
            for (int l = 0; l < LANES; l++) begin
                xs = w_st[g].lane[l].x >>> K;
                ys = w_st[g].lane[l].y >>> K;
                if (!w_st[g].lane[l].y[CW-1]) begin
                    n_st.lane[l].x = w_st[g].lane[l].x + ys;
                    n_st.lane[l].y = w_st[g].lane[l].y - xs;
                    n_st.lane[l].z = w_st[g].lane[l].z + ATAN_TURNS[K];
                end else begin
                    n_st.lane[l].x = w_st[g].lane[l].x - ys;
                    n_st.lane[l].y = w_st[g].lane[l].y + xs;
                    n_st.lane[l].z = w_st[g].lane[l].z - ATAN_TURNS[K];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st.valid <= 1'b0;
            end else if (i_en) begin
                r_st <= n_st;
            end
        end

        assign w_st[g+1] = r_st;
    end

    assign o_vec = w_st[CORDIC_STEPS];

endmodule

### src/cal_scale.sv
// Back end: angle difference, half-turn fold and angle * radius * 2pi product.
module cal_scale (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  cal_pkg::t_vec i_vec,
    output cal_pkg::t_res o_res
);
    import cal_pkg::*;

    logic                    r1_valid;
    logic [ANG_W-2:0]        r1_d;
    logic [IN_W-1:0]         r1_rad;

    logic                    r2_valid;
    logic [ANG_W+IN_W-2:0]   r2_prod;

    logic                    r3_valid;
    logic [ANG_W+IN_W-2:0]   r3_phi;
    logic [IN_W-1:0]         r3_lo;

    logic                    r4_valid;
    logic [ANG_W+IN_W-2:0]   r4_phi;
    logic [IN_W-1:0]         r4_plo;

    t_res                    r5_res;

    logic [ANG_W-1:0]        w_a1;
    logic [ANG_W-1:0]        w_a2;
    logic [ANG_W-1:0]        w_diff;
    logic [2*IN_W-1:0]       w_lo_pi;
    logic [2*IN_W-1:0]       w_acc;

    // endpoint on the centre counts as angle zero; the half-turn fold
    // drops the top bit of the modulo difference
    assign w_a1   = i_vec.lane[0].zero ? '0 : i_vec.lane[0].z;
    assign w_a2   = i_vec.lane[1].zero ? '0 : i_vec.lane[1].z;
    assign w_diff = w_a1 - w_a2;

    assign w_lo_pi = (2*IN_W)'(r3_lo) * (2*IN_W)'(PI_Q30);
    assign w_acc   = {1'b0, r4_phi} + {{IN_W{1'b0}}, r4_plo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r4_valid     <= 1'b0;
            r5_res.valid <= 1'b0;
        end else if (i_en) begin
            // stage 1: folded angle
            r1_valid <= i_vec.valid;
            r1_d     <= w_diff[ANG_W-2:0];
            r1_rad   <= i_vec.radius;
            // stage 2: angle times radius
            r2_valid <= r1_valid;
            r2_prod  <= (ANG_W+IN_W-1)'(r1_d) * (ANG_W+IN_W-1)'(r1_rad);
            // stage 3: upper word times pi
            r3_valid <= r2_valid;
            r3_phi   <= (ANG_W+IN_W-1)'(r2_prod[ANG_W+IN_W-2:IN_W])
                      * (ANG_W+IN_W-1)'(PI_Q30);
            r3_lo    <= r2_prod[IN_W-1:0];
            // stage 4: lower word times pi, upper half kept
            r4_valid <= r3_valid;
            r4_phi   <= r3_phi;
            r4_plo   <= w_lo_pi[2*IN_W-1:IN_W];
            // stage 5: sum and rescale to Q18.16
            r5_res.valid <= r4_valid;
            r5_res.len   <= w_acc[LEN_W+28:29];
        end
    end

    assign o_res = r5_res;

endmodule

### src/circular_arc_length_top.sv
// Top level of the circular arc length pipeline.
//
// Arc length from start point, end point, centre and radius. One arc beat
// is accepted per clock while the skid register is free, and one length
// beat is returned per arc, in order. The pipeline has 3 front-end stages
// (offsets, normalization, scaling), one stage per CORDIC iteration (16 at
// the default step count), 5 back-end stages (angle difference, three
// multiply stages, final add) and the output register. The whole pipeline
// moves as one; a skid register behind it holds one result so that input
// is still taken in the cycle the downstream first stalls. Each endpoint
// angle is atan2(p.y - c.y, c.x - p.x); the start minus end angle is
// wrapped to a full turn and a half turn is removed when it reaches one,
// so the length is always below pi * radius.
`include "assert_macros.svh"

module circular_arc_length_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input arc beats
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // start_x, start_y, end_x, end_y, center_x, center_y, radius (32 bits each)
    input  logic [223:0] i_s_tdata,
    // output length beats
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // arc_length [33:0], zero pad [39:34]
    output logic [39:0]  o_m_tdata
);
    import cal_pkg::*;

    t_in              w_in;
    t_vec             w_front;
    t_vec             w_rot;
    t_res             w_res;
    logic             w_en;
    logic             w_take;

    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_data;
    logic             r_sk_valid;
    logic [LEN_W-1:0] r_sk_data;

    // pipeline advances while the skid register is free
    assign w_en       = !r_sk_valid;
    assign o_s_tready = w_en;

    // unpack input beat
    always_comb begin
        w_in.valid        = i_s_tvalid;
        w_in.arc.start_x  = i_s_tdata[31:0];
        w_in.arc.start_y  = i_s_tdata[63:32];
        w_in.arc.end_x    = i_s_tdata[95:64];
        w_in.arc.end_y    = i_s_tdata[127:96];
        w_in.arc.center_x = i_s_tdata[159:128];
        w_in.arc.center_y = i_s_tdata[191:160];
        w_in.arc.radius   = i_s_tdata[223:192];
    end

    cal_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_in    (w_in),
        .o_vec   (w_front)
    );

    cal_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vec   (w_front),
        .o_vec   (w_rot)
    );

    cal_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vec   (w_rot),
        .o_res   (w_res)
    );

    // output register with one-beat skid
    assign w_take = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (w_take) begin
                r_out_data <= r_sk_data;
                r_sk_valid <= 1'b0;
            end
        end else if (w_res.valid) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_res.len;
            end else begin
                r_sk_valid <= 1'b1;
                r_sk_data  <= w_res.len;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(40-LEN_W){1'b0}}, r_out_data};

    // skid only ever holds a beat behind a waiting output beat
    `CAL_NEVER(a_skid_alone, i_clk, i_rst_n, r_sk_valid && !r_out_valid)
    // skid fills only when the output beat was stalled
    `CAL_ASSERT(a_skid_fill, i_clk, i_rst_n, $rose(r_sk_valid) |-> $past(r_out_valid && !i_m_tready))
    // a drained output beat is refilled from the skid at once
    `CAL_ASSERT(a_skid_drain, i_clk, i_rst_n, (r_sk_valid && i_m_tready) |=> r_out_valid)

endmodule

### verif/circular_arc_length_top_tb.sv
// Self-checking testbench for the circular arc length pipeline.
`timescale 1ns / 100ps

module circular_arc_length_top_tb;
    import cal_pkg::*;

    localparam int  RANDOM_ARCS = 1750;
    localparam int  HOLD_AT     = 600;      // arcs sent before the long output stall
    localparam int  HOLD_CYCLES = 300;
    localparam int  DRAIN_AT    = 1200;     // arcs sent before the sender drains the pipe
    localparam int  TAIL_CYCLES = 40;
    localparam int  CYCLE_LIMIT = 200000;

    localparam logic [31:0] PI_Q2_30  = 32'hC90F_DAA2;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] QTR_TURN  = 32'h4000_0000;

    // atan(2^-k) in turns, 2^32 per turn
    localparam logic [31:0] ATAN_LUT [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Directed row: arc, and a typed length where it is obvious
    typedef struct packed {
        t_arc        arc;
        logic        typed;
        logic [33:0] len;
    } t_arc_row;

    localparam int N_ROWS = 17;
    localparam t_arc_row DIRECTED_ROWS [N_ROWS] = '{
        // both endpoints on the centre, zero radius
        '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 34'd0},
        // both endpoints on the centre, full radius
        '{'{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
            32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF}, 1'b1, 34'd0},
        // coincident endpoints
        '{'{32'h0003_0000, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000,
            32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1, 34'd0},
        // zero radius with distinct directions
        '{'{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0},
          1'b1, 34'd0},
        // same direction, different distance
        '{'{32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'h0004_0000,
            32'h0, 32'h0, 32'h0001_0000}, 1'b1, 34'd0},
        // start on the centre
        '{'{32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0005_0000},
          1'b0, 34'd0},
        // quarter turn
        '{'{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000},
          1'b0, 34'd0},
        // opposite points, both orders
        '{'{32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000},
          1'b0, 34'd0},
        '{'{32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000},
          1'b0, 34'd0},
        '{'{32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF},
          1'b0, 34'd0},
        // coordinate extremes
        '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b0, 34'd0},
        '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b0, 34'd0},
        '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b0, 34'd0},
        '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 34'd0},
        // smallest offsets or smallest radius
        '{'{32'h1, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1}, 1'b0, 34'd0},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0,
            32'h8000_0000}, 1'b0, 34'd0},
        '{'{32'h0, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h1},
          1'b0, 34'd0}
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [223:0] i_s_tdata;    // start_x, start_y, end_x, end_y, center_x, center_y, radius
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [39:0]  o_m_tdata;    // arc_length [33:0], zero pad [39:34]

    logic [33:0]  arc_len_q [$];
    logic [33:0]  want_len;
    int           arcs_sent;
    int           len_mismatches;
    int           cycle_cnt;
    int           burst_left;
    bit           rx_holding;
    bit           rx_hold_done;

    circular_arc_length_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Direction of (x, y) in turns by CORDIC vectoring
    function automatic logic [31:0] endpoint_turns(longint y_in, longint x_in);
        longint      x, y, m, t, xs, ys;
        logic [31:0] z;
        int          k;
        x = x_in;
        y = y_in;
        z = '0;
        if (x == 0 && y == 0)
            return '0;
        m = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        // exact power-of-two normalization to at least 2^40
        while (m < (64'sd1 <<< 40)) begin
            m = m * 2;
            x = x * 2;
            y = y * 2;
        end
        // fold the left half plane onto the right
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QTR_TURN;
            end else begin
                x = -y;
                y = t;
                z = -QTR_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            k  = i % 32;
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_LUT[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_LUT[k];
            end
        end
        return z;
    endfunction

    // Arc length in Q18.16 for one arc
    function automatic logic [33:0] arc_length_q18(t_arc a);
        longint      sx, sy, ex, ey, cx, cy;
        logic [31:0] ang_s, ang_e, sweep;
        logic [63:0] prod, acc;
        sx = a.start_x;
        sy = a.start_y;
        ex = a.end_x;
        ey = a.end_y;
        cx = a.center_x;
        cy = a.center_y;
        // x offset is mirrored: angle of (p.y - c.y, c.x - p.x)
        ang_s = endpoint_turns(sy - cy, cx - sx);
        ang_e = endpoint_turns(ey - cy, cx - ex);
        sweep = ang_s - ang_e;
        if (sweep >= HALF_TURN)
            sweep = sweep - HALF_TURN;
        prod = {32'b0, sweep} * {32'b0, a.radius};
        acc  = {32'b0, prod[63:32]} * {32'b0, PI_Q2_30}
             + (({32'b0, prod[31:0]} * {32'b0, PI_Q2_30}) >> 32);
        return acc[62:29];
    endfunction

    function automatic logic [31:0] rand_offset(int unsigned shift);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> shift;
    endfunction

    // Random arc: plausible geometry, some noise and corner shapes
    function automatic t_arc random_arc();
        t_arc        a;
        logic [31:0] ox, oy, px, py, m;
        int unsigned kind, sh;
        kind = $urandom_range(0, 99);
        sh   = $urandom_range(0, 31);
        a.start_x  = $urandom;
        a.start_y  = $urandom;
        a.end_x    = $urandom;
        a.end_y    = $urandom;
        a.center_x = $urandom;
        a.center_y = $urandom;
        a.radius   = $urandom >> $urandom_range(0, 31);
        ox = rand_offset(sh);
        oy = rand_offset(sh);
        px = rand_offset(sh);
        py = rand_offset(sh);
        if (kind < 20) begin
            // fully random fields
        end else if (kind < 55) begin
            a.center_x = rand_offset($urandom_range(1, 31));
            a.center_y = rand_offset($urandom_range(1, 31));
            a.start_x  = a.center_x + ox;
            a.start_y  = a.center_y + oy;
            a.end_x    = a.center_x + px;
            a.end_y    = a.center_y + py;
        end else if (kind < 63) begin
            // endpoint on the centre
            if ($urandom_range(0, 2) != 1) begin
                a.start_x = a.center_x;
                a.start_y = a.center_y;
            end
            if ($urandom_range(0, 2) != 0) begin
                a.end_x = a.center_x;
                a.end_y = a.center_y;
            end
        end else if (kind < 71) begin
            // same direction: coincident or scaled by a power of two
            a.start_x = a.center_x + ox;
            a.start_y = a.center_y + oy;
            sh = $urandom_range(0, 3);
            a.end_x = a.center_x + (ox <<< sh);
            a.end_y = a.center_y + (oy <<< sh);
        end else if (kind < 79) begin
            // opposite points, half turn apart
            a.start_x = a.center_x + ox;
            a.start_y = a.center_y + oy;
            a.end_x   = a.center_x - ox;
            a.end_y   = a.center_y - oy;
        end else if (kind < 90) begin
            // axis and diagonal directions
            m = ox;
            a.start_x = a.center_x + (($urandom_range(0, 2) == 0) ? 32'h0 : m);
            a.start_y = a.center_y + (($urandom_range(0, 2) == 0) ? 32'h0 : -m);
            a.end_x   = a.center_x + (($urandom_range(0, 2) == 0) ? 32'h0 : -m);
            a.end_y   = a.center_y + (($urandom_range(0, 2) == 0) ? 32'h0 : m);
        end else begin
            // radius extremes
            case ($urandom_range(0, 3))
                0: a.radius = 32'h0;
                1: a.radius = 32'hFFFF_FFFF;
                2: a.radius = 32'h1;
                default: a.radius = 32'h8000_0000;
            endcase
        end
        return a;
    endfunction

    // Offer one arc beat, with burst/gap pacing; returns at the next falling edge
    task automatic offer_arc(input t_arc a, input bit typed, input logic [33:0] typed_len);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = (rx_holding || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {a.radius, a.center_y, a.center_x, a.end_y, a.end_x,
                       a.start_y, a.start_x};
        do @(posedge i_clk); while (!o_s_tready);
        arc_len_q.push_back(typed ? typed_len : arc_length_q18(a));
        arcs_sent++;
        @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        arcs_sent  = 0;
        burst_left = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[i])
            offer_arc(DIRECTED_ROWS[i].arc, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].len);

        for (int n = 0; n < RANDOM_ARCS; n++) begin
            offer_arc(random_arc(), 1'b0, '0);
            if (arcs_sent == DRAIN_AT) begin
                // let the pipeline run dry before going on
                i_s_tvalid <= 1'b0;
                while (arc_len_q.size() != 0) @(negedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;

        while (arc_len_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (len_mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Output ready: changing patterns, plus one long stall
    initial begin
        int unsigned mode, span, tick;
        i_m_tready   = 1'b0;
        rx_holding   = 1'b0;
        rx_hold_done = 1'b0;
        tick         = 0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 80);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                if (!rx_hold_done && arcs_sent >= HOLD_AT) begin
                    rx_holding = 1'b1;
                    i_m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    rx_holding   = 1'b0;
                    rx_hold_done = 1'b1;
                end
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_tready <= (tick % 3 == 0);
                    default: i_m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Length beat checker
    initial len_mismatches = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (arc_len_q.size() == 0) begin
                $error("length beat with none expected: %h", o_m_tdata);
                len_mismatches++;
            end else begin
                want_len = arc_len_q.pop_front();
                if (o_m_tdata[33:0] !== want_len) begin
                    $error("arc_length: expected %h, got %h", want_len, o_m_tdata[33:0]);
                    len_mismatches++;
                end
                if (o_m_tdata[39:34] !== 6'b0) begin
                    $error("pad: expected %h, got %h", 6'b0, o_m_tdata[39:34]);
                    len_mismatches++;
                end
            end
        end
    end

    // Run limit
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

### filelist.f
+incdir+src
src/cal_pkg.sv
src/cal_front.sv
src/cal_cordic.sv
src/cal_scale.sv
src/circular_arc_length_top.sv
verif/circular_arc_length_top_tb.sv
